/* rtl/core/wsa_pkg.sv */
// Shared types and constants for the wheel speed weighted average block.
// Used by every module under rtl/core; depends on nothing.
package wsa_pkg;

   localparam int DIVIDEND_W  = 32;   // capture count
   localparam int DIVISOR_W   = 8;    // cycles per microsecond setting
   localparam int RING_AW_MAX = 9;    // address bits for 8 wheels x 64 teeth

   // Configuration register indexes
   localparam logic [1:0] CSR_CYCLES_PER_US = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_MS    = 2'd1;
   localparam logic [1:0] CSR_READ_PERIOD   = 2'd2;

   // Input item commands
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic        command;
      logic [2:0]  wheel;
      logic [31:0] capture_cycles;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  report_wheel;
      logic [31:0] edge_total;
      logic [31:0] last_interval_us;
      logic [31:0] average_interval_us;
      logic        is_stopped;
      logic        last_of_run;
   } rsp_item_type;

   // Ring memory access from the controller
   typedef struct packed {
      logic                   rd_en;
      logic [RING_AW_MAX-1:0] rd_addr;
      logic                   wr_en;
      logic [RING_AW_MAX-1:0] wr_addr;
      logic [31:0]            wr_data;
   } ring_cmd_type;

endpackage

/* rtl/core/wsa_divider.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on wsa_pkg for the operand widths.
module wsa_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [wsa_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [wsa_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            busy,
   output logic [wsa_pkg::DIVIDEND_W-1:0]  quotient
);
   import wsa_pkg::*;

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;

   // Operand load on start, otherwise one shift-subtract step while busy
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      trial    = {rem_ff, quot_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(DIVIDEND_W);
         quot_in  = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dvs_ff});
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

/* rtl/core/wsa_ring_mem.sv */
// Interval ring storage for all wheels: one write and one registered read port.
// Clears itself after reset, one entry a cycle. Depends on wsa_pkg.
module wsa_ring_mem #(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wsa_pkg::ring_cmd_type cmd,
   output logic [31:0]           rd_data,
   output logic                  clearing
);
   import wsa_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic [AW:0]   clr_cnt_ff, clr_cnt_in;
   logic          clr_busy;

   assign clr_busy   = (clr_cnt_ff < (AW+1)'(DEPTH));
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + (AW+1)'(1) : clr_cnt_ff;

   // Clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Storage: sweep writes zero, otherwise the controller writes
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem[clr_cnt_ff[AW-1:0]] <= '0;
      end else if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy;

endmodule

/* rtl/core/wheel_speed_weighted_average.sv */
// Wheel speed tracker: tooth-edge and millisecond-tick items in, one report per wheel
// on each due report run out. An edge on a tracked wheel runs a 32-step serial divide
// of the capture count by cycles_per_microsecond, then ring write and sum update; an
// edge on a disregarded or out-of-range wheel is handled straight from idle. A tick
// checks whether a report run is due; if so, each wheel in turn has a ring read, a
// four-step reciprocal multiply of the weighted sum and a result load, which waits
// while the result register is held by the receiver. After reset the ring memory is
// cleared before the first item is taken.
// Depends on wsa_pkg, wsa_divider, wsa_ring_mem.
module wheel_speed_weighted_average #(
   parameter int WHEEL_COUNT = 2,
   parameter int TOOTH_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wsa_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wsa_pkg::rsp_item_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_write_data
);
   import wsa_pkg::*;

   localparam int DEPTH  = WHEEL_COUNT * TOOTH_COUNT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW     = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
   localparam int PW     = $clog2(TOOTH_COUNT);
   localparam int WEIGHT_TOTAL = TOOTH_COUNT * (TOOTH_COUNT + 1) / 2;
   // Reciprocal of the weight total, exact floor for any 48-bit weighted sum
   localparam int RK     = 48 + $clog2(WEIGHT_TOTAL);
   localparam logic [63:0] RECIP =
      ((64'd1 << RK) + 64'(WEIGHT_TOTAL - 1)) / 64'(WEIGHT_TOTAL);

   typedef enum logic [2:0] {
      ST_IDLE, ST_E_DIV, ST_E_MUL, ST_E_ACC, ST_T_CHK, ST_R_START, ST_R_MUL, ST_R_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [7:0]    cpu_ff, cpu_in;
   logic [15:0]   timeout_ff, timeout_in;
   logic [15:0]   period_ff, period_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   last_rep_ff, last_rep_in;
   logic [31:0]   count_ff    [WHEEL_COUNT];
   logic [31:0]   count_in    [WHEEL_COUNT];
   logic [PW-1:0] pos_ff      [WHEEL_COUNT];
   logic [PW-1:0] pos_in      [WHEEL_COUNT];
   logic [47:0]   wsum_ff     [WHEEL_COUNT];
   logic [47:0]   wsum_in     [WHEEL_COUNT];
   logic [39:0]   win_ff      [WHEEL_COUNT];
   logic [39:0]   win_in      [WHEEL_COUNT];
   logic          ign_ff      [WHEEL_COUNT];
   logic          ign_in      [WHEEL_COUNT];
   logic [31:0]   ledge_ff    [WHEEL_COUNT];
   logic [31:0]   ledge_in    [WHEEL_COUNT];
   logic [WW-1:0] w_ff, w_in;
   logic [31:0]   interval_ff, interval_in;
   logic [31:0]   dropped_ff, dropped_in;
   logic [38:0]   prod_ff, prod_in;
   logic [1:0]    mul_cnt_ff, mul_cnt_in;
   logic [97:0]   acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   ring_cmd_type          ring_cmd;
   logic [31:0]           ring_rd;
   logic                  clearing;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_busy;
   logic [DIVIDEND_W-1:0] div_quot;
   logic                  accept;
   logic                  rsp_free;
   logic                  timed_out;
   logic [PW-1:0]         last_pos;
   logic [23:0]           mul_a;
   logic [24:0]           mul_b;
   logic [48:0]           mul_pp;
   logic [97:0]           mul_term;

   assign req_ready = (state_ff == ST_IDLE) && !clearing;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign timed_out = (ledge_ff[w_ff] + {16'd0, timeout_ff}) < now_ff;
   assign last_pos  = (pos_ff[w_ff] == '0) ? PW'(TOOTH_COUNT - 1)
                                           : pos_ff[w_ff] - PW'(1);

   // Partial product of weighted sum and reciprocal, one 24x25 slice per step
   assign mul_a    = mul_cnt_ff[0] ? wsum_ff[w_ff][47:24] : wsum_ff[w_ff][23:0];
   assign mul_b    = mul_cnt_ff[1] ? RECIP[49:25] : RECIP[24:0];
   assign mul_pp   = 49'(mul_a) * 49'(mul_b);
   assign mul_term = 98'(mul_pp) << ((mul_cnt_ff[0] ? 24 : 0) + (mul_cnt_ff[1] ? 25 : 0));

   wsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   wsa_ring_mem #(.DEPTH(DEPTH)) u_ring (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ring_cmd),
      .rd_data  (ring_rd),
      .clearing (clearing)
   );

   // Control sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      cpu_in       = cpu_ff;
      timeout_in   = timeout_ff;
      period_in    = period_ff;
      now_in       = now_ff;
      last_rep_in  = last_rep_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      wsum_in      = wsum_ff;
      win_in       = win_ff;
      ign_in       = ign_ff;
      ledge_in     = ledge_ff;
      w_in         = w_ff;
      interval_in  = interval_ff;
      dropped_in   = dropped_ff;
      prod_in      = prod_ff;
      mul_cnt_in   = mul_cnt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ring_cmd     = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      // Configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CYCLES_PER_US: cpu_in     = csr_write_data[7:0];
            CSR_TIMEOUT_MS:    timeout_in = csr_write_data;
            CSR_READ_PERIOD:   period_in  = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_TICK) begin
                  now_in   = now_ff + 32'd1;
                  state_in = ST_T_CHK;
               end else if (32'(req_data.wheel) < 32'(WHEEL_COUNT)) begin
                  w_in = WW'(req_data.wheel);
                  if (ign_ff[WW'(req_data.wheel)]) begin
                     // Disregarded wheel: restart its statistics
                     count_in[WW'(req_data.wheel)] = '0;
                     pos_in[WW'(req_data.wheel)]   = '0;
                     wsum_in[WW'(req_data.wheel)]  = '0;
                     win_in[WW'(req_data.wheel)]   = '0;
                     ledge_in[WW'(req_data.wheel)] = now_ff;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = req_data.capture_cycles;
                     div_divisor  = (cpu_ff == 8'd0) ? DIVISOR_W'(1) : DIVISOR_W'(cpu_ff);
                     ring_cmd.rd_en   = 1'b1;
                     ring_cmd.rd_addr = RING_AW_MAX'(AW'(
                        int'(req_data.wheel) * TOOTH_COUNT
                        + int'(pos_ff[WW'(req_data.wheel)])));
                     state_in = ST_E_DIV;
                  end
               end
            end
         end
         ST_E_DIV: begin
            if (!div_busy) begin
               interval_in = div_quot[31:0];
               state_in    = ST_E_MUL;
            end
         end
         ST_E_MUL: begin
            // Weighted newest sample, oldest sample leaving the window
            prod_in    = 39'(interval_ff) * 39'(TOOTH_COUNT);
            dropped_in = (count_ff[w_ff] < 32'(TOOTH_COUNT)) ? 32'd0 : ring_rd;
            ring_cmd.wr_en   = 1'b1;
            ring_cmd.wr_addr = RING_AW_MAX'(AW'(int'(w_ff) * TOOTH_COUNT
                                                + int'(pos_ff[w_ff])));
            ring_cmd.wr_data = interval_ff;
            state_in = ST_E_ACC;
         end
         ST_E_ACC: begin
            wsum_in[w_ff]  = wsum_ff[w_ff] + 48'(prod_ff) - 48'(win_ff[w_ff]);
            win_in[w_ff]   = win_ff[w_ff] + 40'(interval_ff) - 40'(dropped_ff);
            count_in[w_ff] = count_ff[w_ff] + 32'd1;
            pos_in[w_ff]   = (pos_ff[w_ff] == PW'(TOOTH_COUNT - 1)) ? '0
                                                                     : pos_ff[w_ff] + PW'(1);
            ledge_in[w_ff] = now_ff;
            state_in       = ST_IDLE;
         end
         ST_T_CHK: begin
            if ((last_rep_ff + {16'd0, period_ff}) < now_ff) begin
               last_rep_in = now_ff;
               w_in        = '0;
               state_in    = ST_R_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_R_START: begin
            acc_in     = '0;
            mul_cnt_in = '0;
            ring_cmd.rd_en   = 1'b1;
            ring_cmd.rd_addr = RING_AW_MAX'(AW'(int'(w_ff) * TOOTH_COUNT
               + ((count_ff[w_ff] == 32'd0) ? 0 : int'(last_pos))));
            state_in = ST_R_MUL;
         end
         ST_R_MUL: begin
            // Weighted sum times reciprocal, one slice a cycle
            acc_in     = acc_ff + mul_term;
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd3) begin
               state_in = ST_R_OUT;
            end
         end
         ST_R_OUT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.report_wheel     = 3'(w_ff);
               rsp_in.edge_total       = count_ff[w_ff];
               rsp_in.last_interval_us = ring_rd;
               rsp_in.average_interval_us =
                  (count_ff[w_ff] >= 32'(TOOTH_COUNT)) ? acc_ff[RK +: 32] : 32'd0;
               rsp_in.is_stopped       = timed_out || (count_ff[w_ff] == 32'd0);
               rsp_in.last_of_run      = (32'(w_ff) == 32'(WHEEL_COUNT - 1));
               ign_in[w_ff]            = timed_out;
               if (32'(w_ff) == 32'(WHEEL_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  w_in     = w_ff + WW'(1);
                  state_in = ST_R_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpu_ff       <= 8'd12;
         timeout_ff   <= 16'd100;
         period_ff    <= 16'd10;
         now_ff       <= '0;
         last_rep_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            count_ff[i] <= '0;
            pos_ff[i]   <= '0;
            wsum_ff[i]  <= '0;
            win_ff[i]   <= '0;
            ign_ff[i]   <= 1'b0;
            ledge_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cpu_ff       <= cpu_in;
         timeout_ff   <= timeout_in;
         period_ff    <= period_in;
         now_ff       <= now_in;
         last_rep_ff  <= last_rep_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         wsum_ff      <= wsum_in;
         win_ff       <= win_in;
         ign_ff       <= ign_in;
         ledge_ff     <= ledge_in;
      end
      w_ff        <= w_in;
      interval_ff <= interval_in;
      dropped_ff  <= dropped_in;
      prod_ff     <= prod_in;
      mul_cnt_ff  <= mul_cnt_in;
      acc_ff      <= acc_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The divider is never left running when a new item may enter
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("divider busy while taking an item");

   // No item is taken during the ring clearing sweep
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("item taken during ring clear");

   // The run marker goes only with the highest wheel
   a_last_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> 32'(rsp_data.report_wheel) == 32'(WHEEL_COUNT - 1))
      else $error("last_of_run on wrong wheel");
`endif

endmodule

/* verif/wheel_speed_weighted_average_tb.sv */
// Self-checking bench for wheel_speed_weighted_average: tooth edges and ms ticks
// in, per-wheel speed reports out, checked against an in-bench model. Needs wsa_pkg.
module wheel_speed_weighted_average_tb;
   import wsa_pkg::*;

   localparam int WHEELS = 2;
   localparam int TEETH = 16;
   localparam int WEIGHT_SUM = TEETH * (TEETH + 1) / 2;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;

   wheel_speed_weighted_average #(.WHEEL_COUNT(WHEELS), .TOOTH_COUNT(TEETH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state
   logic [7:0]  cyc_per_us;
   logic [15:0] timeout_set;
   logic [15:0] period_set;
   logic [31:0] now_ms, last_report_ms;
   logic [31:0] ring [WHEELS][TEETH];
   logic [31:0] edge_cnt [WHEELS];
   int          ring_pos [WHEELS];
   logic [47:0] wsum [WHEELS];
   logic [39:0] psum [WHEELS];
   logic        ignore_wheel [WHEELS];
   logic [31:0] last_edge_ms [WHEELS];

   rsp_item_type expected_reports[$];
   int  errors = 0;
   bit  idle_enable = 1'b1;
   bit  rx_hold = 1'b0;
   int  quiet_cycles = 0;

   task automatic model_reset();
      cyc_per_us = 8'd12; timeout_set = 16'd100; period_set = 16'd10;
      now_ms = '0; last_report_ms = '0;
      for (int w = 0; w < WHEELS; w++) begin
         for (int t = 0; t < TEETH; t++) ring[w][t] = '0;
         edge_cnt[w] = '0; ring_pos[w] = 0; wsum[w] = '0; psum[w] = '0;
         ignore_wheel[w] = 1'b0; last_edge_ms[w] = '0;
      end
   endtask

   // Predict reports caused by one accepted item
   task automatic predict_speed(input req_item_type it);
      logic [31:0] div, ivl, dropped;
      logic [63:0] avg;
      int w, idx;
      rsp_item_type r;
      if (it.command == CMD_EDGE) begin
         w = it.wheel;
         if (w >= WHEELS) return;
         div = (cyc_per_us == 0) ? 32'd1 : {24'd0, cyc_per_us};
         ivl = it.capture_cycles / div;
         if (ignore_wheel[w]) begin
            edge_cnt[w] = '0; ring_pos[w] = 0; wsum[w] = '0; psum[w] = '0;
         end else begin
            dropped = (edge_cnt[w] < TEETH) ? 32'd0 : ring[w][ring_pos[w]];
            ring[w][ring_pos[w]] = ivl;
            edge_cnt[w] = edge_cnt[w] + 1;
            ring_pos[w] = (ring_pos[w] + 1) % TEETH;
            wsum[w] = wsum[w] + 48'(TEETH) * 48'(ivl) - 48'(psum[w]);
            psum[w] = psum[w] + 40'(ivl) - 40'(dropped);
         end
         last_edge_ms[w] = now_ms;
         return;
      end
      now_ms = now_ms + 1;
      if (!(32'(last_report_ms + period_set) < now_ms)) return;
      last_report_ms = now_ms;
      for (w = 0; w < WHEELS; w++) begin
         r = '0;
         idx = (edge_cnt[w] > 0) ? (ring_pos[w] + TEETH - 1) % TEETH : 0;
         avg = (edge_cnt[w] >= TEETH) ? 64'(wsum[w]) / WEIGHT_SUM : 64'd0;
         r.report_wheel = 3'(w);
         r.edge_total = edge_cnt[w];
         r.last_interval_us = ring[w][idx];
         r.average_interval_us = avg[31:0];
         ignore_wheel[w] = 32'(last_edge_ms[w] + timeout_set) < now_ms;
         r.is_stopped = ignore_wheel[w] || (edge_cnt[w] == 0);
         r.last_of_run = (w == WHEELS - 1);
         expected_reports.push_back(r);
      end
   endtask

   // Send one item, with random gaps in front; valid stays up for the next item
   task automatic send_item(input req_item_type it);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_speed(it);
      @(negedge clock);
   endtask

   task automatic send_edge(input int w, input logic [31:0] cyc);
      req_item_type it;
      it.command = CMD_EDGE; it.wheel = 3'(w); it.capture_cycles = cyc;
      send_item(it);
   endtask

   task automatic send_tick();
      req_item_type it;
      it.command = CMD_TICK; it.wheel = 3'($urandom); it.capture_cycles = $urandom;
      send_item(it);
   endtask

   // Write a register once everything has drained
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CYCLES_PER_US: cyc_per_us = val[7:0];
         CSR_TIMEOUT_MS:    timeout_set = val;
         CSR_READ_PERIOD:   period_set = val;
         default: ;
      endcase
   endtask

   // Receiver readiness: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (reset || rx_hold) rsp_ready <= 1'b0;
      else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
         rsp_ready <= 1'b1;
      end else rsp_ready <= 1'b1;
   end

   // Result checker
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report for wheel %0d", rsp_data.report_wheel);
            errors++;
         end else begin
            e = expected_reports.pop_front();
            if (rsp_data.report_wheel !== e.report_wheel) begin
               $error("report_wheel exp %0d got %0d", e.report_wheel, rsp_data.report_wheel);
               errors++;
            end
            if (rsp_data.edge_total !== e.edge_total) begin
               $error("edge_total exp %0d got %0d", e.edge_total, rsp_data.edge_total);
               errors++;
            end
            if (rsp_data.last_interval_us !== e.last_interval_us) begin
               $error("last_interval_us exp %0d got %0d",
                      e.last_interval_us, rsp_data.last_interval_us);
               errors++;
            end
            if (rsp_data.average_interval_us !== e.average_interval_us) begin
               $error("average_interval_us exp %0d got %0d",
                      e.average_interval_us, rsp_data.average_interval_us);
               errors++;
            end
            if (rsp_data.is_stopped !== e.is_stopped) begin
               $error("is_stopped exp %0b got %0b", e.is_stopped, rsp_data.is_stopped);
               errors++;
            end
            if (rsp_data.last_of_run !== e.last_of_run) begin
               $error("last_of_run exp %0b got %0b", e.last_of_run, rsp_data.last_of_run);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || csr_write_enable)
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Extremes of fields, out-of-range wheels, wrap of the ring, zero divisor
   task automatic test_directed();
      send_edge(0, 32'hFFFF_FFFF);
      send_edge(1, 32'd0);
      send_edge(7, 32'h5555_AAAA);
      send_edge(2, 32'd1234);
      for (int i = 0; i < 17; i++) send_edge(0, 32'd12000 + 32'(i * 37));
      repeat (12) send_tick();
      write_csr(CSR_CYCLES_PER_US, 16'd0);
      send_edge(1, 32'hFFFF_FFFF);
      send_edge(1, 32'hAAAA_5555);
      repeat (12) send_tick();
   endtask

   // Timeout and ignore: wheel goes quiet, then its next edge clears it
   task automatic test_timeout();
      write_csr(CSR_TIMEOUT_MS, 16'd1);
      write_csr(CSR_READ_PERIOD, 16'd1);
      repeat (6) send_tick();
      send_edge(0, 32'd500);
      send_edge(1, 32'd700);
      repeat (4) send_tick();
      write_csr(CSR_TIMEOUT_MS, 16'hFFFF);
      write_csr(CSR_CYCLES_PER_US, 16'd255);
   endtask

   // Hold the receiver off while ticks keep flowing
   task automatic test_backpressure();
      write_csr(CSR_READ_PERIOD, 16'd1);
      fork
         begin
            rx_hold = 1'b1;
            repeat (600) @(negedge clock);
            rx_hold = 1'b0;
         end
         repeat (20) send_tick();
      join
   endtask

   // Random mix, mostly valid wheels, with the settings changed at the midpoint
   task automatic test_random(input int count);
      logic [31:0] cyc;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            write_csr(CSR_CYCLES_PER_US, 16'($urandom_range(1, 255)));
            write_csr(CSR_TIMEOUT_MS, 16'($urandom_range(1, 40)));
            write_csr(CSR_READ_PERIOD, 16'($urandom_range(1, 4)));
         end
         if (i == count * 3 / 4) idle_enable = 1'b0;
         if ($urandom_range(0, 2) == 0) send_tick();
         else begin
            cyc = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 100000));
            send_edge(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                  : $urandom_range(0, WHEELS - 1), cyc);
         end
      end
   endtask

   initial begin
      model_reset();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_timeout();
      test_backpressure();
      write_csr(CSR_READ_PERIOD, 16'd2);
      write_csr(CSR_TIMEOUT_MS, 16'd30);
      test_random(231);
      write_csr(CSR_READ_PERIOD, 16'hFFFF);
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && expected_reports.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
